// ===== design/gdc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdc_pkg
// Types, pipeline stage records and calendar tables shared by the Gregorian
// date calculator.
// ----------------------------------------------------------------------------
package gdc_pkg;

  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [5:0]  day;
    logic [8:0]  yday_query;
  } gdc_in_t;

  typedef struct packed {
    logic        is_leap;
    logic [8:0]  year_days;
    logic [4:0]  month_days;
    logic [8:0]  days_through_month;
    logic [8:0]  day_of_year;
    logic [2:0]  weekday;
    logic [3:0]  month_of_yday;
    logic        month_bad;
    logic        day_bad;
    logic        accum_month_bad;
    logic        yday_bad;
  } gdc_out_t;

  // After the reciprocal multiplies.
  typedef struct packed {
    logic [15:0] year;
    logic [15:0] wyear;      // year shifted back for January and February
    logic [3:0]  month;
    logic [5:0]  day;
    logic [8:0]  yq;
    logic [9:0]  year_cent;  // year / 100
    logic [9:0]  wyear_cent; // wyear / 100
    logic [4:0]  qbase;      // yday_query / 30
  } gdc_s1_t;

  // After the remainder and the leap decision.
  typedef struct packed {
    logic        leap;
    logic        year_zero;
    logic [3:0]  month;
    logic [5:0]  day;
    logic [8:0]  yq;
    logic [6:0]  yy;
    logic [9:0]  cent;
    logic [4:0]  qbase;
  } gdc_s2_t;

  // After lengths, flags and the weekday sum.
  typedef struct packed {
    logic        leap;
    logic [4:0]  mdays;
    logic [8:0]  through;
    logic [8:0]  yday;
    logic [3:0]  qmonth;
    logic        mbad;
    logic        dbad;
    logic        abad;
    logic        qbad;
    logic [13:0] wsum;
  } gdc_s3_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    if (m == MonthFeb) begin
      len = {4'b1110, leap};
    end else begin
      len = {4'b1111, m[0] ^ m[3]};
    end
    return len;
  endfunction

  // Days in the first m months of a common year, plus one past February when leap.
  function automatic logic [8:0] accum_days(input logic leap, input logic [4:0] m);
    logic [8:0] base;
    unique case (m)
      5'd0:    base = 9'd0;
      5'd1:    base = 9'd31;
      5'd2:    base = 9'd59;
      5'd3:    base = 9'd90;
      5'd4:    base = 9'd120;
      5'd5:    base = 9'd151;
      5'd6:    base = 9'd181;
      5'd7:    base = 9'd212;
      5'd8:    base = 9'd243;
      5'd9:    base = 9'd273;
      5'd10:   base = 9'd304;
      5'd11:   base = 9'd334;
      5'd12:   base = 9'd365;
      default: base = 9'd0;
    endcase
    if (m >= 5'd2) begin
      base = base + {8'd0, leap};
    end
    return base;
  endfunction

  // floor(26 * (m' + 1) / 10), where January and February count as 13 and 14.
  function automatic logic [5:0] zeller_month(input logic [3:0] m);
    logic [5:0] t;
    unique case (m)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== design/gregorian_date_calculator.sv =====
// Pipeline: four register stages (div, leap, cal, out); the edge that accepts an input
// beat loads the first, and the beat then passes through each stage in turn to out_valid.
// Throughput: one beat per cycle through the divide, leap, calendar and weekday
// reduction stages; a stalled output fills bubbles before in_ready drops.
// Reset: synchronous, active low rst_n clears the stage valid bits only.
// ----------------------------------------------------------------------------
// gregorian_date_calculator
// Stateless Gregorian calendar unit: leap year, month and year lengths, day of
// year, weekday and the month of a queried day of year, with range flags.
// ----------------------------------------------------------------------------
module gregorian_date_calculator
  import gdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  gdc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output gdc_out_t out_data
);

  logic    s1_valid;
  logic    s1_ready;
  gdc_s1_t s1_data;
  logic    s2_valid;
  logic    s2_ready;
  gdc_s2_t s2_data;
  logic    s3_valid;
  logic    s3_ready;
  gdc_s3_t s3_data;

  gdc_div_stage u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  gdc_leap_stage u_leap (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  gdc_cal_stage u_cal (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  gdc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_data  (s3_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule

// ===== design/gdc_div_stage.sv =====
// ----------------------------------------------------------------------------
// gdc_div_stage
// First pipeline stage: divides the year and the January/February-shifted year
// by 100 and the day-of-year query by 30 through reciprocal multiplies.
// ----------------------------------------------------------------------------
module gdc_div_stage
  import gdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  gdc_in_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output gdc_s1_t dn_data
);

  logic        vld_r;
  logic        vld_nxt;
  gdc_s1_t     data_r;
  gdc_s1_t     data_nxt;
  logic [15:0] wyear;
  logic [32:0] prod_y;
  logic [32:0] prod_w;
  logic [18:0] prod_q;

  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  // 83887 / 2^23 and 547 / 2^14 give exact quotients over the input ranges.
  always_comb begin
    wyear  = (up_data.month <= MonthFeb) ? (up_data.year - 16'd1) : up_data.year;
    prod_y = {17'd0, up_data.year} * 33'd83887;
    prod_w = {17'd0, wyear} * 33'd83887;
    prod_q = {10'd0, up_data.yday_query} * 19'd547;
    data_nxt.year       = up_data.year;
    data_nxt.wyear      = wyear;
    data_nxt.month      = up_data.month;
    data_nxt.day        = up_data.day;
    data_nxt.yq         = up_data.yday_query;
    data_nxt.year_cent  = prod_y[32:23];
    data_nxt.wyear_cent = prod_w[32:23];
    data_nxt.qbase      = prod_q[18:14];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== design/gdc_leap_stage.sv =====
// ----------------------------------------------------------------------------
// gdc_leap_stage
// Second pipeline stage: forms the shifted year's remainder by 100 and decides the leap year.
// ----------------------------------------------------------------------------
module gdc_leap_stage
  import gdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  gdc_s1_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output gdc_s2_t dn_data
);

  logic        vld_r;
  logic        vld_nxt;
  gdc_s2_t     data_r;
  gdc_s2_t     data_nxt;
  logic [15:0] year_hund;
  logic [15:0] wyear_hund;
  logic [15:0] wyear_rem;

  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  // A year divisible by 100 is leap only when its century count is a multiple of 4.
  always_comb begin
    year_hund  = {6'd0, up_data.year_cent} * 16'd100;
    wyear_hund = {6'd0, up_data.wyear_cent} * 16'd100;
    wyear_rem  = up_data.wyear - wyear_hund;
    data_nxt.leap      = (up_data.year[1:0] == 2'b00) &&
                         ((up_data.year != year_hund) || (up_data.year_cent[1:0] == 2'b00));
    data_nxt.year_zero = (up_data.year == 16'd0);
    data_nxt.month     = up_data.month;
    data_nxt.day       = up_data.day;
    data_nxt.yq        = up_data.yq;
    data_nxt.yy        = wyear_rem[6:0];
    data_nxt.cent      = up_data.wyear_cent;
    data_nxt.qbase     = up_data.qbase;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== design/gdc_cal_stage.sv =====
// ----------------------------------------------------------------------------
// gdc_cal_stage
// Third pipeline stage: month lengths, accumulated days, range flags, the
// month of the queried day of year and the raw weekday sum.
// ----------------------------------------------------------------------------
module gdc_cal_stage
  import gdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  gdc_s2_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output gdc_s3_t dn_data
);

  logic       vld_r;
  logic       vld_nxt;
  gdc_s3_t    data_r;
  gdc_s3_t    data_nxt;
  logic [4:0] mlen;
  logic [8:0] ydays;
  logic       mbad;
  logic       dbad;
  logic       abad;
  logic       qbad;
  logic [3:0] month_prev;

  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  always_comb begin
    mlen       = month_len(up_data.leap, up_data.month);
    ydays      = 9'd365 + {8'd0, up_data.leap};
    month_prev = up_data.month - 4'd1;
    mbad       = (up_data.month == 4'd0) || (up_data.month > MonthDec);
    abad       = (up_data.month > MonthDec);
    // Without a valid month there is no length to check the day against.
    dbad       = !mbad && ((up_data.day == 6'd0) || (up_data.day > {1'b0, mlen}) ||
                           up_data.year_zero);
    qbad       = (up_data.yq == 9'd0) || (up_data.yq > ydays);

    data_nxt.leap    = up_data.leap;
    data_nxt.mdays   = mbad ? 5'd0 : mlen;
    data_nxt.through = abad ? 9'd0 : accum_days(up_data.leap, {1'b0, up_data.month});
    data_nxt.yday    = (mbad || dbad) ? 9'd0 :
                       (accum_days(up_data.leap, {1'b0, month_prev}) + {3'd0, up_data.day});
    // The query lies past month qbase once it exceeds the days through qbase.
    data_nxt.qmonth  = qbad ? 4'd0 :
                       (up_data.qbase[3:0] +
                        {3'd0, (up_data.yq > accum_days(up_data.leap, up_data.qbase))});
    data_nxt.mbad    = mbad;
    data_nxt.dbad    = dbad;
    data_nxt.abad    = abad;
    data_nxt.qbad    = qbad;
    data_nxt.wsum    = {7'd0, up_data.yy} + {9'd0, up_data.yy[6:2]} +
                       {6'd0, up_data.cent[9:2]} + ({4'd0, up_data.cent} * 14'd12) +
                       {8'd0, zeller_month(up_data.month)} + {8'd0, up_data.day} - 14'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== design/gdc_out_stage.sv =====
// ----------------------------------------------------------------------------
// gdc_out_stage
// Last pipeline stage: reduces the weekday sum modulo 7 and holds the
// result beat in the output register.
// ----------------------------------------------------------------------------
module gdc_out_stage
  import gdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  gdc_s3_t  up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output gdc_out_t dn_data
);

  logic     vld_r;
  logic     vld_nxt;
  gdc_out_t data_r;
  gdc_out_t data_nxt;
  logic [4:0] fold1;
  logic [3:0] fold2;
  logic [2:0] wday;

  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  // Since 8 is 1 modulo 7, summing the octal digits keeps the residue.
  always_comb begin
    fold1 = {2'd0, up_data.wsum[2:0]} + {2'd0, up_data.wsum[5:3]} +
            {2'd0, up_data.wsum[8:6]} + {2'd0, up_data.wsum[11:9]} +
            {3'd0, up_data.wsum[13:12]};
    fold2 = {1'b0, fold1[2:0]} + {2'd0, fold1[4:3]};
    if (fold2 >= 4'd7) begin
      wday = fold2[2:0] - 3'd7;
    end else begin
      wday = fold2[2:0];
    end

    data_nxt.is_leap            = up_data.leap;
    data_nxt.year_days          = 9'd365 + {8'd0, up_data.leap};
    data_nxt.month_days         = up_data.mdays;
    data_nxt.days_through_month = up_data.through;
    data_nxt.day_of_year        = up_data.yday;
    data_nxt.weekday            = (up_data.mbad || up_data.dbad) ? 3'd0 : wday;
    data_nxt.month_of_yday      = up_data.qmonth;
    data_nxt.month_bad          = up_data.mbad;
    data_nxt.day_bad            = up_data.dbad;
    data_nxt.accum_month_bad    = up_data.abad;
    data_nxt.yday_bad           = up_data.qbad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule
